// ===== rtl/dtds_pkg.sv =====
`timescale 1ns / 1ps

package dtds_pkg;

  typedef enum logic [1:0] {
    ACT_POSE   = 2'd0,
    ACT_TARGET = 2'd1,
    ACT_TICK   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    CFG_SUM_MODE = 2'd0,
    CFG_SCALE    = 2'd1,
    CFG_DECAY    = 2'd2
  } cfg_reg_e;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned MagW      = 32;
  localparam int unsigned ScaleW    = 20;
  localparam int unsigned DecayW    = 17;
  localparam int unsigned ScoreW    = 63;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 20;
  // widest freshness weight over the supported fraction range
  localparam int unsigned FracMax   = 24;
  localparam int unsigned WeightW   = FracMax + 1;

  localparam logic [ScaleW-1:0] ScaleReset = 20'd6554;
  localparam logic [DecayW-1:0] DecayReset = 17'd58982;

  typedef struct packed {
    logic [MagW-1:0]    ax;
    logic [MagW-1:0]    ay;
    logic [WeightW-1:0] weight;
    logic               last;
  } pose_entry_t;

  localparam int unsigned EntryW = $bits(pose_entry_t);

endpackage

// ===== rtl/dtds_fifo.sv =====
`timescale 1ns / 1ps

module dtds_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/dtds_front.sv =====
`timescale 1ns / 1ps

module dtds_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [1:0]                    action_i,
  input  logic [dtds_pkg::CoordW-1:0]   pos_x_i,
  input  logic [dtds_pkg::CoordW-1:0]   pos_y_i,
  input  logic                          last_pose_i,
  input  logic [dtds_pkg::DecayW-1:0]   decay_i,
  output logic                          q_push_o,
  output dtds_pkg::pose_entry_t         q_entry_o,
  input  logic                          q_full_i
);

  localparam int unsigned FreshW    = FRAC_BITS + 1;
  localparam int unsigned TickW     = FreshW + dtds_pkg::DecayW;
  localparam int unsigned ThreshInt = ((1 << FRAC_BITS) + 5) / 10;
  localparam logic [FreshW-1:0] OneQ    = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FreshW-1:0] ThreshQ = FreshW'(ThreshInt);

  logic [dtds_pkg::CoordW-1:0] goal_x_q, goal_x_d;
  logic [dtds_pkg::CoordW-1:0] goal_y_q, goal_y_d;
  logic [FreshW-1:0]           fresh_q, fresh_d;

  logic                        accept;
  dtds_pkg::action_e           act;
  logic [dtds_pkg::CoordW:0]   dx, dy, mag_x, mag_y;
  logic [TickW-1:0]            tick_prod, tick_sh;
  logic [FreshW-1:0]           tick_fresh;

  assign full_o = q_full_i;
  assign accept = push_i && !q_full_i;
  assign act    = dtds_pkg::action_e'(action_i);

  // distance components against the current target, sign-extended to 33 bits
  assign dx    = {pos_x_i[dtds_pkg::CoordW-1], pos_x_i}
               - {goal_x_q[dtds_pkg::CoordW-1], goal_x_q};
  assign dy    = {pos_y_i[dtds_pkg::CoordW-1], pos_y_i}
               - {goal_y_q[dtds_pkg::CoordW-1], goal_y_q};
  assign mag_x = dx[dtds_pkg::CoordW] ? (~dx + 1'b1) : dx;
  assign mag_y = dy[dtds_pkg::CoordW] ? (~dy + 1'b1) : dy;

  // decay step, clamped at one
  assign tick_prod  = TickW'(fresh_q) * TickW'(decay_i);
  assign tick_sh    = tick_prod >> FRAC_BITS;
  assign tick_fresh = (tick_sh > TickW'(OneQ)) ? OneQ : tick_sh[FreshW-1:0];

  assign q_entry_o.ax     = mag_x[dtds_pkg::MagW-1:0];
  assign q_entry_o.ay     = mag_y[dtds_pkg::MagW-1:0];
  // stale freshness weighs the pose at zero
  assign q_entry_o.weight = (fresh_q >= ThreshQ) ? dtds_pkg::WeightW'(fresh_q) : '0;
  assign q_entry_o.last   = last_pose_i;

  always_comb begin
    q_push_o = 1'b0;
    goal_x_d = goal_x_q;
    goal_y_d = goal_y_q;
    fresh_d  = fresh_q;
    unique case (act)
      dtds_pkg::ACT_POSE: begin
        q_push_o = accept;
      end
      dtds_pkg::ACT_TARGET: begin
        if (accept) begin
          goal_x_d = pos_x_i;
          goal_y_d = pos_y_i;
          fresh_d  = OneQ;
        end
      end
      dtds_pkg::ACT_TICK: begin
        if (accept) begin
          fresh_d = tick_fresh;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q <= '0;
      goal_y_q <= '0;
      fresh_q  <= '0;
    end else begin
      goal_x_q <= goal_x_d;
      goal_y_q <= goal_y_d;
      fresh_q  <= fresh_d;
    end
  end

endmodule

// ===== rtl/dtds_back.sv =====
`timescale 1ns / 1ps

module dtds_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dtds_pkg::pose_entry_t       q_entry_i,
  input  logic                        q_empty_i,
  output logic                        q_pop_o,
  input  logic                        sum_mode_i,
  input  logic [dtds_pkg::ScaleW-1:0] scale_i,
  output logic                        out_push_o,
  output logic [dtds_pkg::ScoreW-1:0] out_score_o,
  input  logic                        out_full_i
);

  localparam int unsigned SqW    = 2 * dtds_pkg::MagW;
  localparam int unsigned RadW   = SqW + 2;
  localparam int unsigned RootW  = RadW / 2;
  localparam int unsigned RemW   = RootW + 3;
  localparam int unsigned StepW  = $clog2(RootW);
  localparam int unsigned ProdW  = RootW + dtds_pkg::ScaleW;
  localparam int unsigned ScW    = ProdW - FRAC_BITS;
  localparam int unsigned WProdW = ScW + FRAC_BITS + 1;
  localparam int unsigned TermW  = WProdW - FRAC_BITS;
  localparam int unsigned SumW   = dtds_pkg::ScoreW + 1;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SQX    = 8'b0000_0010,
    ST_SQY    = 8'b0000_0100,
    ST_ADD    = 8'b0000_1000,
    ST_ROOT   = 8'b0001_0000,
    ST_SCALE  = 8'b0010_0000,
    ST_WEIGHT = 8'b0100_0000,
    ST_ACC    = 8'b1000_0000
  } state_e;

  state_e                      state_q, state_d;
  logic [StepW-1:0]            step_q, step_d;
  logic [dtds_pkg::ScoreW-1:0] running_q, running_d;

  dtds_pkg::pose_entry_t entry_q;
  logic [SqW-1:0]        sq_x_q, sq_y_q;
  logic [RadW-1:0]       rad_q;
  logic [RemW-1:0]       rem_q;
  logic [RootW-1:0]      root_q;
  logic [ScW-1:0]        scaled_q;
  logic [TermW-1:0]      term_q;

  logic [dtds_pkg::MagW-1:0]   mul_op;
  logic [SqW-1:0]              sq;
  logic [RemW+1:0]             rem_sh, trial;
  logic                        ge;
  logic [ProdW-1:0]            scaled_prod;
  logic [WProdW-1:0]           weighted;
  logic [SumW-1:0]             sum;
  logic [dtds_pkg::ScoreW-1:0] sum_sat, new_run;

  // one squarer shared by both components
  assign mul_op = (state_q == ST_SQY) ? entry_q.ay : entry_q.ax;
  assign sq     = SqW'(mul_op) * SqW'(mul_op);

  // restoring square root, two radicand bits per cycle
  assign rem_sh = {rem_q, rad_q[RadW-1 -: 2]};
  assign trial  = (RemW + 2)'({root_q, 2'b01});
  assign ge     = (rem_sh >= trial);

  assign scaled_prod = ProdW'(root_q) * ProdW'(scale_i);
  assign weighted    = WProdW'(scaled_q) * WProdW'(entry_q.weight[FRAC_BITS:0]);

  assign sum     = {1'b0, running_q} + SumW'(term_q);
  assign sum_sat = sum[SumW-1] ? '1 : sum[dtds_pkg::ScoreW-1:0];
  assign new_run = sum_mode_i ? sum_sat : dtds_pkg::ScoreW'(term_q);

  assign q_pop_o     = (state_q == ST_IDLE) && !q_empty_i;
  assign out_push_o  = (state_q == ST_ACC) && entry_q.last && !out_full_i;
  assign out_score_o = new_run;

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    running_d = running_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          state_d = ST_SQX;
        end
      end
      ST_SQX: state_d = ST_SQY;
      ST_SQY: state_d = ST_ADD;
      ST_ADD: begin
        step_d  = StepW'(RootW - 1);
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (step_q == '0) begin
          state_d = ST_SCALE;
        end else begin
          step_d = step_q - StepW'(1);
        end
      end
      ST_SCALE:  state_d = ST_WEIGHT;
      ST_WEIGHT: state_d = ST_ACC;
      ST_ACC: begin
        if (!entry_q.last) begin
          running_d = new_run;
          state_d   = ST_IDLE;
        end else if (!out_full_i) begin
          // score leaves, next trajectory starts from zero
          running_d = '0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      running_q <= '0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      running_q <= running_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      entry_q <= q_entry_i;
    end
    if (state_q == ST_SQX) begin
      sq_x_q <= sq;
    end
    if (state_q == ST_SQY) begin
      sq_y_q <= sq;
    end
    if (state_q == ST_ADD) begin
      rad_q  <= RadW'(sq_x_q) + RadW'(sq_y_q);
      rem_q  <= '0;
      root_q <= '0;
    end
    if (state_q == ST_ROOT) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? RemW'(rem_sh - trial) : RemW'(rem_sh);
      root_q <= {root_q[RootW-2:0], ge};
    end
    if (state_q == ST_SCALE) begin
      scaled_q <= scaled_prod[ProdW-1:FRAC_BITS];
    end
    if (state_q == ST_WEIGHT) begin
      term_q <= weighted[WProdW-1:FRAC_BITS];
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> !out_full_i)
    else $error("score pushed into full result queue");

  a_root_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT && state_d != ST_ROOT) |-> (step_q == '0))
    else $error("square root left before all digits");

  a_pop_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == ST_SQX))
    else $error("popped pose did not start processing");

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |=> (running_q == '0))
    else $error("running score not cleared after emit");

endmodule

// ===== rtl/decaying_target_distance_score.sv =====
// Trajectory scorer against a decaying target. Poses, new-target and tick
// items enter through the push/full side; target and tick items update the
// front-end target and freshness registers when accepted, while each pose
// is queued (two deep) with its distance components and freshness weight.
// The back end handles one pose at a time: it takes it from the queue, runs
// both components through the shared 32x32 squarer, adds them, takes the
// two-bits-per-cycle square root of the 66-bit radicand, does the scale and
// freshness multiplies, and accumulates. A pose marked last places its
// score in a two-entry result queue read through empty/pop; the back end
// holds while that queue is full.
// Configuration writes are always accepted and should happen only while idle.
`timescale 1ns / 1ps

module decaying_target_distance_score #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     action_i,
  input  logic [dtds_pkg::CoordW-1:0]    pos_x_i,
  input  logic [dtds_pkg::CoordW-1:0]    pos_y_i,
  input  logic                           last_pose_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [dtds_pkg::ScoreW-1:0]    score_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dtds_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [dtds_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic                        sum_mode_q;
  logic [dtds_pkg::ScaleW-1:0] scale_q;
  logic [dtds_pkg::DecayW-1:0] decay_q;

  logic                        mid_push, mid_full, mid_pop, mid_empty;
  dtds_pkg::pose_entry_t       mid_in, mid_out;
  logic                        res_push, res_full;
  logic [dtds_pkg::ScoreW-1:0] res_score;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_mode_q <= 1'b0;
      scale_q    <= dtds_pkg::ScaleReset;
      decay_q    <= dtds_pkg::DecayReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (dtds_pkg::cfg_reg_e'(cfg_index_i))
        dtds_pkg::CFG_SUM_MODE: sum_mode_q <= cfg_data_i[0];
        dtds_pkg::CFG_SCALE:    scale_q    <= cfg_data_i[dtds_pkg::ScaleW-1:0];
        dtds_pkg::CFG_DECAY:    decay_q    <= cfg_data_i[dtds_pkg::DecayW-1:0];
        default: begin
        end
      endcase
    end
  end

  dtds_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .full_o      (full),
    .action_i,
    .pos_x_i,
    .pos_y_i,
    .last_pose_i,
    .decay_i     (decay_q),
    .q_push_o    (mid_push),
    .q_entry_o   (mid_in),
    .q_full_i    (mid_full)
  );

  dtds_fifo #(
    .Width(dtds_pkg::EntryW),
    .Depth(2)
  ) u_pose_q (
    .clk_i,
    .rst_ni,
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty)
  );

  dtds_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .q_entry_i   (mid_out),
    .q_empty_i   (mid_empty),
    .q_pop_o     (mid_pop),
    .sum_mode_i  (sum_mode_q),
    .scale_i     (scale_q),
    .out_push_o  (res_push),
    .out_score_o (res_score),
    .out_full_i  (res_full)
  );

  dtds_fifo #(
    .Width(dtds_pkg::ScoreW),
    .Depth(2)
  ) u_result_q (
    .clk_i,
    .rst_ni,
    .push_i  (res_push),
    .data_i  (res_score),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (score_o),
    .empty_o (empty)
  );

endmodule

// ===== bench/tb_decaying_target_distance_score.sv =====
`timescale 1ns / 1ps

module tb_decaying_target_distance_score;

  localparam int unsigned Frac        = 16;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned PhaseItems  = 130;
  localparam logic [1:0]  ActUnused   = 2'd3;
  localparam logic [16:0] FreshOne    = 17'(2 ** Frac);
  localparam logic [16:0] FreshFloor  = 17'((2 ** Frac + 5) / 10);
  localparam logic [62:0] ScoreMax    = {63{1'b1}};

  typedef struct {
    bit                 is_cfg;
    dtds_pkg::cfg_reg_e reg_sel;
    logic [19:0]        cfg_val;
    logic [1:0]         act;
    logic [31:0]        x;
    logic [31:0]        y;
    logic               last;
    bit                 typed;
    logic [62:0]        score;
  } step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  action_i = dtds_pkg::ACT_POSE;
  logic [31:0] pos_x_i = '0;
  logic [31:0] pos_y_i = '0;
  logic        last_pose_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [62:0] score_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = dtds_pkg::CFG_SUM_MODE;
  logic [19:0] cfg_data_i = '0;

  // mirror of the block's registers and state
  logic               sum_mode_m = 1'b0;
  logic [19:0]        scale_m = dtds_pkg::ScaleReset;
  logic [16:0]        decay_m = dtds_pkg::DecayReset;
  logic signed [31:0] goal_x_m = '0;
  logic signed [31:0] goal_y_m = '0;
  logic [16:0]        fresh_m = '0;
  logic [62:0]        run_score_m = '0;

  logic [62:0] score_q[$];
  step_t       plan[$];
  int unsigned mismatches = 0;
  int unsigned fed = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  bit          typed_pending = 1'b0;
  logic [62:0] typed_score = '0;
  logic [31:0] aim_x = '0;
  logic [31:0] aim_y = '0;

  decaying_target_distance_score #(
    .FRAC_BITS(Frac)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .action_i   (action_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .last_pose_i(last_pose_i),
    .empty      (empty),
    .pop        (pop),
    .score_o    (score_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("decaying_target_distance_score: mismatch");
    $finish;
  end

  function automatic logic [32:0] floor_sqrt66(input logic [65:0] rad);
    logic [33:0] root;
    logic [67:0] rem;
    logic [67:0] trial;
    root = '0;
    rem  = '0;
    for (int i = 32; i >= 0; i--) begin
      rem   = {rem[65:0], rad[2*i +: 2]};
      trial = {32'd0, root, 2'b01};
      if (rem >= trial) begin
        rem  = rem - trial;
        root = {root[32:0], 1'b1};
      end else begin
        root = {root[32:0], 1'b0};
      end
    end
    return root[32:0];
  endfunction

  function automatic logic [62:0] weighted_distance(input logic [31:0] x, input logic [31:0] y);
    logic [32:0] dx, dy, nx, ny;
    logic [31:0] ax, ay;
    logic [65:0] rad;
    logic [63:0] t;
    if (fresh_m < FreshFloor) return '0;
    dx  = {x[31], x} - {goal_x_m[31], goal_x_m};
    dy  = {y[31], y} - {goal_y_m[31], goal_y_m};
    nx  = -dx;
    ny  = -dy;
    ax  = dx[32] ? nx[31:0] : dx[31:0];
    ay  = dy[32] ? ny[31:0] : dy[31:0];
    rad = {34'd0, ax} * {34'd0, ax} + {34'd0, ay} * {34'd0, ay};
    t   = (64'(floor_sqrt66(rad)) * 64'(scale_m)) >> Frac;
    t   = (t * 64'(fresh_m)) >> Frac;
    return t[62:0];
  endfunction

  // advance the mirrored state by one request; true when a score comes out
  function automatic bit apply_request(input logic [1:0] act, input logic [31:0] x,
                                       input logic [31:0] y, input logic last,
                                       output logic [62:0] score);
    logic [62:0] term;
    logic [63:0] total;
    logic [34:0] decayed;
    bit          emits;
    emits = 1'b0;
    score = '0;
    case (act)
      dtds_pkg::ACT_POSE: begin
        term = weighted_distance(x, y);
        if (sum_mode_m) begin
          total       = 64'(run_score_m) + 64'(term);
          run_score_m = (total > 64'(ScoreMax)) ? ScoreMax : total[62:0];
        end else begin
          run_score_m = term;
        end
        if (last) begin
          score       = run_score_m;
          run_score_m = '0;
          emits       = 1'b1;
        end
      end
      dtds_pkg::ACT_TARGET: begin
        goal_x_m = x;
        goal_y_m = y;
        fresh_m  = FreshOne;
      end
      dtds_pkg::ACT_TICK: begin
        decayed = (35'(fresh_m) * 35'(decay_m)) >> Frac;
        fresh_m = (decayed > 35'(FreshOne)) ? FreshOne : decayed[16:0];
      end
      default: ;
    endcase
    return emits;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: %s", $time, msg);
  endtask

  always @(posedge clk_i) begin : observe
    logic [62:0] predicted;
    logic [62:0] want;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        dtds_pkg::CFG_SUM_MODE: sum_mode_m = cfg_data_i[0];
        dtds_pkg::CFG_SCALE:    scale_m    = cfg_data_i[19:0];
        dtds_pkg::CFG_DECAY:    decay_m    = cfg_data_i[16:0];
        default: ;
      endcase
    end
    // check the pop before queueing, so a stray score is never masked
    if (pop && !empty) begin
      if (score_q.size() == 0) begin
        report_mismatch($sformatf("score %0d with none expected", score_o));
      end else begin
        want = score_q.pop_front();
        if (score_o !== want) begin
          report_mismatch($sformatf("score %0d, expected %0d", score_o, want));
        end
      end
    end
    if (push && !full) begin
      if (apply_request(action_i, pos_x_i, pos_y_i, last_pose_i, predicted)) begin
        score_q.push_back(typed_pending ? typed_score : predicted);
      end
    end
  end

  always @(negedge clk_i) begin
    pop = ($urandom_range(99) >= stall_pct);
  end

  task automatic send_request(input logic [1:0] act, input logic [31:0] x,
                              input logic [31:0] y, input logic last,
                              input bit typed = 1'b0, input logic [62:0] want = '0);
    while ($urandom_range(99) < gap_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push          = 1'b1;
    action_i      = act;
    pos_x_i       = x;
    pos_y_i       = y;
    last_pose_i   = last;
    typed_pending = typed;
    typed_score   = want;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
    if (act != ActUnused) fed++;
  endtask

  // drop the request line and let the pipeline run dry
  task automatic hold_for_idle();
    push = 1'b0;
    while (score_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input dtds_pkg::cfg_reg_e sel, input logic [19:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = sel;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic step_t row_item(input logic [1:0] act, input logic [31:0] x,
                                     input logic [31:0] y, input logic last);
    step_t s;
    s        = '{reg_sel: dtds_pkg::CFG_SUM_MODE, default: '0};
    s.act    = act;
    s.x      = x;
    s.y      = y;
    s.last   = last;
    return s;
  endfunction

  function automatic step_t row_check(input logic [1:0] act, input logic [31:0] x,
                                      input logic [31:0] y, input logic last,
                                      input logic [62:0] score);
    step_t s;
    s       = row_item(act, x, y, last);
    s.typed = 1'b1;
    s.score = score;
    return s;
  endfunction

  function automatic step_t row_reg(input dtds_pkg::cfg_reg_e sel, input logic [19:0] val);
    step_t s;
    s         = row_item(dtds_pkg::ACT_POSE, '0, '0, 1'b0);
    s.is_cfg  = 1'b1;
    s.reg_sel = sel;
    s.cfg_val = val;
    return s;
  endfunction

  function automatic logic [31:0] pick_coord(input logic [31:0] base);
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3: return base + {{12{r[19]}}, r[19:0]};
      4, 5, 6:    return r;
      7: begin
        case (r[1:0])
          2'd0:    return 32'h8000_0000;
          2'd1:    return 32'h7fff_ffff;
          2'd2:    return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default:    return base + {{4{r[27]}}, r[27:0]};
    endcase
  endfunction

  task automatic random_settings();
    logic [19:0] v;
    hold_for_idle();
    write_reg(dtds_pkg::CFG_SUM_MODE, 20'($urandom));
    case ($urandom_range(5))
      0:       v = 20'd0;
      1:       v = 20'hfffff;
      2:       v = 20'h10000;
      3:       v = dtds_pkg::ScaleReset;
      default: v = 20'($urandom);
    endcase
    write_reg(dtds_pkg::CFG_SCALE, v);
    case ($urandom_range(7))
      0:       v = 20'd0;
      1:       v = 20'h10000;
      2:       v = 20'h1ffff;
      3:       v = 20'($urandom);
      default: v = 20'($urandom_range(52000, 65536));
    endcase
    // upper data bits beyond the register width must be ignored
    write_reg(dtds_pkg::CFG_DECAY, {3'($urandom), v[16:0]});
  endtask

  // one trajectory with its target and ticks, or some stray or broken traffic
  task automatic send_sequence();
    int unsigned kind;
    int unsigned n_ticks;
    int unsigned n_poses;
    kind = $urandom_range(99);
    if (kind < 8) begin
      case ($urandom_range(2))
        0:       send_request(ActUnused, $urandom, $urandom, 1'($urandom));
        1:       send_request(dtds_pkg::ACT_TICK, $urandom, $urandom, 1'($urandom));
        default: send_request(dtds_pkg::ACT_POSE, pick_coord(aim_x), pick_coord(aim_y),
                              1'($urandom));
      endcase
    end else begin
      if (kind >= 20) begin
        aim_x = pick_coord(aim_x);
        aim_y = pick_coord(aim_y);
        send_request(dtds_pkg::ACT_TARGET, aim_x, aim_y, 1'($urandom));
      end
      n_ticks = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 3);
      repeat (n_ticks) send_request(dtds_pkg::ACT_TICK, $urandom, $urandom, 1'($urandom));
      n_poses = $urandom_range(1, 6);
      for (int k = 1; k <= n_poses; k++) begin
        if (k > 1 && $urandom_range(39) == 0) begin
          hold_for_idle();
          write_reg(dtds_pkg::CFG_SUM_MODE, 20'($urandom));
        end
        if (k > 1 && $urandom_range(19) == 0) begin
          send_request(dtds_pkg::ACT_TICK, $urandom, $urandom, 1'($urandom));
        end
        // leave some trajectories open so they run into the next one
        send_request(dtds_pkg::ACT_POSE, pick_coord(aim_x), pick_coord(aim_y),
                     (k == n_poses) && !(kind < 12));
      end
    end
  endtask

  initial begin
    bit prev_cfg;
    prev_cfg = 1'b0;

    // freshness is zero out of reset, so every term is zero
    plan.push_back(row_check(dtds_pkg::ACT_POSE, 32'h7fff_ffff, 32'h8000_0000, 1'b1, '0));
    plan.push_back(row_item(dtds_pkg::ACT_TICK, 32'h0, 32'h0, 1'b1));
    plan.push_back(row_check(dtds_pkg::ACT_POSE, 32'h0, 32'h0, 1'b1, '0));
    plan.push_back(row_item(dtds_pkg::ACT_TARGET, 32'h0, 32'h0, 1'b1));
    plan.push_back(row_check(dtds_pkg::ACT_POSE, 32'h0, 32'h0, 1'b1, '0));
    plan.push_back(row_item(dtds_pkg::ACT_POSE, 32'h0001_0000, 32'h0, 1'b0));
    plan.push_back(row_item(dtds_pkg::ACT_POSE, 32'h8000_0000, 32'h8000_0000, 1'b1));
    plan.push_back(row_item(dtds_pkg::ACT_TARGET, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0));
    plan.push_back(row_item(dtds_pkg::ACT_POSE, 32'h8000_0000, 32'h8000_0000, 1'b1));
    plan.push_back(row_item(ActUnused, 32'hffff_ffff, 32'hffff_ffff, 1'b1));
    plan.push_back(row_reg(dtds_pkg::CFG_SCALE, 20'hfffff));
    plan.push_back(row_item(dtds_pkg::ACT_POSE, 32'h8000_0000, 32'h7fff_ffff, 1'b1));
    plan.push_back(row_reg(dtds_pkg::CFG_SUM_MODE, 20'd1));
    plan.push_back(row_item(dtds_pkg::ACT_POSE, 32'h8000_0000, 32'h8000_0000, 1'b0));
    plan.push_back(row_item(dtds_pkg::ACT_POSE, 32'h0, 32'h0, 1'b0));
    // switch back to keep-last between poses of one trajectory
    plan.push_back(row_reg(dtds_pkg::CFG_SUM_MODE, 20'd0));
    plan.push_back(row_item(dtds_pkg::ACT_POSE, 32'h1234_5678, 32'hedcb_a987, 1'b1));
    plan.push_back(row_reg(dtds_pkg::CFG_DECAY, 20'h1ffff));
    plan.push_back(row_item(dtds_pkg::ACT_TICK, 32'h0, 32'h0, 1'b0));
    plan.push_back(row_item(dtds_pkg::ACT_POSE, 32'h0, 32'h0, 1'b1));
    // one tick lands freshness exactly on the floor, then one step under it
    plan.push_back(row_reg(dtds_pkg::CFG_DECAY, 20'(FreshFloor)));
    plan.push_back(row_item(dtds_pkg::ACT_TARGET, 32'h0, 32'h0, 1'b0));
    plan.push_back(row_item(dtds_pkg::ACT_TICK, 32'h0, 32'h0, 1'b0));
    plan.push_back(row_item(dtds_pkg::ACT_POSE, 32'h7fff_ffff, 32'h0, 1'b1));
    plan.push_back(row_reg(dtds_pkg::CFG_DECAY, 20'(FreshFloor - 1)));
    plan.push_back(row_item(dtds_pkg::ACT_TARGET, 32'h0, 32'h0, 1'b0));
    plan.push_back(row_item(dtds_pkg::ACT_TICK, 32'h0, 32'h0, 1'b0));
    plan.push_back(row_check(dtds_pkg::ACT_POSE, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, '0));
    plan.push_back(row_reg(dtds_pkg::CFG_SCALE, 20'd0));
    plan.push_back(row_item(dtds_pkg::ACT_TARGET, 32'h0, 32'h0, 1'b0));
    plan.push_back(row_check(dtds_pkg::ACT_POSE, 32'h8000_0000, 32'h7fff_ffff, 1'b1, '0));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!prev_cfg) hold_for_idle();
        write_reg(plan[i].reg_sel, plan[i].cfg_val);
      end else begin
        send_request(plan[i].act, plan[i].x, plan[i].y, plan[i].last,
                     plan[i].typed, plan[i].score);
      end
      prev_cfg = plan[i].is_cfg;
    end

    for (int p = 0; p < 8; p++) begin
      random_settings();
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 47; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 47; end
        default: begin gap_pct = 21; stall_pct = 21; end
      endcase
      fed = 0;
      while (fed < PhaseItems) send_sequence();
    end

    hold_for_idle();
    if (mismatches == 0) begin
      $display("decaying_target_distance_score: match");
    end else begin
      $display("decaying_target_distance_score: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dtds_pkg.sv
rtl/dtds_fifo.sv
rtl/dtds_front.sv
rtl/dtds_back.sv
rtl/decaying_target_distance_score.sv
bench/tb_decaying_target_distance_score.sv
